FILE: hdl/sks_pkg.sv
// Shared types, constants and deck permutation functions for the Solitaire keystream cipher.
// Every other file in this block imports this package.
package sks_pkg;

   localparam int DECK_SIZE     = 54;
   localparam int ALPHABET_SIZE = 26;
   localparam int CARD_W        = 6;
   localparam int IDX_W         = 6;

   localparam logic [CARD_W-1:0] JOKER_A    = 6'd53;
   localparam logic [CARD_W-1:0] JOKER_B    = 6'd54;
   localparam logic [CARD_W-1:0] LAST_PLAIN = 6'd52;
   localparam logic [IDX_W-1:0]  LAST_POS   = 6'(DECK_SIZE - 1);
   localparam logic [4:0]        ALPHA      = 5'(ALPHABET_SIZE);

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_RESTART = 2'd1;
   localparam logic [1:0] ACT_ENCRYPT = 2'd2;
   localparam logic [1:0] ACT_DECRYPT = 2'd3;

   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_RESTART = 3'd2;
   localparam logic [2:0] OP_LATCH   = 3'd3;
   localparam logic [2:0] OP_MOVEA   = 3'd4;
   localparam logic [2:0] OP_MOVEB   = 3'd5;
   localparam logic [2:0] OP_TCUT    = 3'd6;
   localparam logic [2:0] OP_CCUT    = 3'd7;

   localparam logic [1:0] RSP_ZERO   = 2'd0;
   localparam logic [1:0] RSP_ERR    = 2'd1;
   localparam logic [1:0] RSP_CIPHER = 2'd2;

   typedef logic [DECK_SIZE-1:0][CARD_W-1:0] deck_type;

   typedef struct packed {
      logic [2:0] op;
      logic       rsp_we;
      logic [1:0] rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic jokers_ok;
      logic out_plain;
   } stat_type;

   // Returns {found, index} of the first card holding the value.
   function automatic logic [IDX_W:0] find_card(deck_type d, logic [CARD_W-1:0] v);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = DECK_SIZE - 1; i >= 0; i--) begin
         if (d[i] == v) begin
            r = {1'b1, IDX_W'(i)};
         end
      end
      return r;
   endfunction

   function automatic logic [CARD_W-1:0] clamp_count(logic [CARD_W-1:0] v);
      return (v >= JOKER_A) ? JOKER_A : v;
   endfunction

   // Takes the card at p out and reinserts it so that it sits at q.
   function automatic deck_type relocate(deck_type d, logic [IDX_W-1:0] p,
                                         logic [IDX_W-1:0] q);
      deck_type r;
      r = d;
      for (int i = 0; i < DECK_SIZE; i++) begin
         if (IDX_W'(i) == q) begin
            r[i] = d[p];
         end else if (q > p) begin
            if (IDX_W'(i) >= p && IDX_W'(i) < q && i < DECK_SIZE - 1) begin
               r[i] = d[i+1];
            end
         end else begin
            if (IDX_W'(i) > q && IDX_W'(i) <= p && i > 0) begin
               r[i] = d[i-1];
            end
         end
      end
      return r;
   endfunction

   function automatic deck_type triple_cut(deck_type d, logic [IDX_W-1:0] lo,
                                           logic [IDX_W-1:0] hi);
      deck_type       r;
      logic [IDX_W:0] len1;
      logic [IDX_W:0] len2;
      logic [IDX_W:0] k;
      logic [IDX_W:0] src;
      len1 = (IDX_W+1)'(LAST_POS) - {1'b0, hi};
      len2 = len1 + {1'b0, hi} - {1'b0, lo} + 7'd1;
      for (int i = 0; i < DECK_SIZE; i++) begin
         k = (IDX_W+1)'(i);
         if (k < len1) begin
            src = {1'b0, hi} + 7'd1 + k;
         end else if (k < len2) begin
            src = {1'b0, lo} + k - len1;
         end else begin
            src = k - len2;
         end
         r[i] = d[src[IDX_W-1:0]];
      end
      return r;
   endfunction

   function automatic deck_type count_cut(deck_type d);
      deck_type        r;
      logic [CARD_W-1:0] n;
      logic [IDX_W:0]  s;
      r = d;
      n = clamp_count(d[DECK_SIZE-1]);
      if (n != '0 && n < LAST_POS) begin
         for (int i = 0; i < DECK_SIZE - 1; i++) begin
            s = (IDX_W+1)'(i) + {1'b0, n};
            if (s >= (IDX_W+1)'(LAST_POS)) begin
               s = s - (IDX_W+1)'(LAST_POS);
            end
            r[i] = d[s[IDX_W-1:0]];
         end
      end
      return r;
   endfunction

endpackage

FILE: hdl/sks_ctrl.sv
// Sequencing controller for the Solitaire keystream cipher.
// Depends on sks_pkg; drives the datapath through command and status structs.
module sks_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_action,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output sks_pkg::cmd_type cmd,
   input  sks_pkg::stat_type stat
);
   import sks_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOVEA = 3'd1;
   localparam logic [2:0] S_MOVEB = 3'd2;
   localparam logic [2:0] S_TCUT  = 3'd3;
   localparam logic [2:0] S_CCUT  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] tries_ff, tries_in;
   logic       valid_ff, valid_in;
   logic       slot_free;
   logic       accept;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      tries_in     = tries_ff;
      cmd.op       = OP_NOP;
      cmd.rsp_we   = 1'b0;
      cmd.rsp_kind = RSP_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_LOAD: begin
                     cmd.op     = OP_LOAD;
                     cmd.rsp_we = 1'b1;
                  end
                  ACT_RESTART: begin
                     cmd.op     = OP_RESTART;
                     cmd.rsp_we = 1'b1;
                  end
                  default: begin
                     if (stat.jokers_ok) begin
                        cmd.op   = OP_LATCH;
                        tries_in = '0;
                        state_in = S_MOVEA;
                     end else begin
                        cmd.rsp_we   = 1'b1;
                        cmd.rsp_kind = RSP_ERR;
                     end
                  end
               endcase
            end
         end
         S_MOVEA: begin
            cmd.op   = OP_MOVEA;
            state_in = S_MOVEB;
         end
         S_MOVEB: begin
            cmd.op   = OP_MOVEB;
            state_in = S_TCUT;
         end
         S_TCUT: begin
            cmd.op   = OP_TCUT;
            state_in = S_CCUT;
         end
         S_CCUT: begin
            cmd.op   = OP_CCUT;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (stat.out_plain || tries_ff == '1) begin
               if (slot_free) begin
                  cmd.rsp_we   = 1'b1;
                  cmd.rsp_kind = stat.out_plain ? RSP_CIPHER : RSP_ERR;
                  state_in     = S_IDLE;
               end
            end else begin
               tries_in = tries_ff + 6'd1;
               state_in = S_MOVEA;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.rsp_we) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tries_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tries_ff <= tries_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: hdl/sks_dpath.sv
// Deck registers, permutation steps and letter arithmetic for the Solitaire cipher.
// Depends on sks_pkg; sequenced by sks_ctrl.
module sks_dpath (
   input  logic              clock,
   input  sks_pkg::cmd_type  cmd,
   output sks_pkg::stat_type stat,
   input  logic [1:0]        req_action,
   input  logic [5:0]        req_position,
   input  logic [5:0]        req_card,
   input  logic [4:0]        req_letter,
   output logic [4:0]        rsp_keystream,
   output logic [4:0]        rsp_letter_out,
   output logic              rsp_status
);
   import sks_pkg::*;

   deck_type   key_ff;
   deck_type   work_ff;
   logic [4:0] letter_ff;
   logic       decrypt_ff;
   logic [4:0] ks_ff, lout_ff;
   logic       st_ff;

   logic [IDX_W:0]    fa, fb;
   logic [IDX_W-1:0]  pa, pb, qa, qb, lo, hi;
   logic [CARD_W-1:0] out_card;
   logic [4:0]        ks, lout, letter_red;
   logic [5:0]        sum;

   assign fa = find_card(work_ff, JOKER_A);
   assign fb = find_card(work_ff, JOKER_B);
   assign pa = fa[IDX_W-1:0];
   assign pb = fb[IDX_W-1:0];
   assign qa = (pa < LAST_POS) ? pa + 6'd1 : 6'd1;
   assign qb = (pb < LAST_POS - 6'd1) ? pb + 6'd2 : pb - 6'(DECK_SIZE - 3);
   assign lo = (pa < pb) ? pa : pb;
   assign hi = (pa < pb) ? pb : pa;

   assign out_card       = work_ff[clamp_count(work_ff[0])];
   assign stat.jokers_ok = fa[IDX_W] && fb[IDX_W];
   assign stat.out_plain = out_card <= LAST_PLAIN;

   assign letter_red = (req_letter >= ALPHA) ? req_letter - ALPHA : req_letter;

   always_comb begin
      if (out_card == '0) begin
         ks = ALPHA;
      end else if (out_card <= 6'(ALPHABET_SIZE)) begin
         ks = out_card[4:0];
      end else begin
         ks = 5'(out_card - 6'(ALPHABET_SIZE));
      end
      if (decrypt_ff) begin
         sum = {1'b0, letter_ff} + {1'b0, ALPHA} - {1'b0, ks};
      end else begin
         sum = {1'b0, letter_ff} + {1'b0, ks};
      end
      lout = (sum >= {1'b0, ALPHA}) ? 5'(sum - {1'b0, ALPHA}) : sum[4:0];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            if (req_position <= LAST_POS) begin
               key_ff[req_position] <= req_card;
            end
         end
         OP_RESTART: work_ff <= key_ff;
         OP_LATCH: begin
            letter_ff  <= letter_red;
            decrypt_ff <= (req_action == ACT_DECRYPT);
         end
         OP_MOVEA: work_ff <= relocate(work_ff, pa, qa);
         OP_MOVEB: work_ff <= relocate(work_ff, pb, qb);
         OP_TCUT:  work_ff <= triple_cut(work_ff, lo, hi);
         OP_CCUT:  work_ff <= count_cut(work_ff);
         default: begin
         end
      endcase
      if (cmd.rsp_we) begin
         unique case (cmd.rsp_kind)
            RSP_CIPHER: begin
               ks_ff   <= ks;
               lout_ff <= lout;
               st_ff   <= 1'b0;
            end
            RSP_ERR: begin
               ks_ff   <= '0;
               lout_ff <= '0;
               st_ff   <= 1'b1;
            end
            default: begin
               ks_ff   <= '0;
               lout_ff <= '0;
               st_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_keystream  = ks_ff;
   assign rsp_letter_out = lout_ff;
   assign rsp_status     = st_ff;

endmodule

FILE: hdl/solitaire_keystream_cipher_top.sv
// Top level of the Solitaire keystream cipher: stream ports, controller and datapath.
// Depends on sks_pkg, sks_ctrl and sks_dpath.
//
//   Channel  Direction  Payload
//   req      in         action, position, card, letter
//   rsp      out        keystream, letter_out, status
//
// Load and restart requests write their deck and register a zero response straight from idle.
// An encrypt or decrypt request runs five deck steps in turn: move joker A, move joker B,
// triple cut, count cut, output check, all on the register deck.
// A joker output repeats the five steps, at most 64 passes per request, then answers with status set.
// Reset is synchronous and clears only control state; both decks are undefined until loaded.
// A response waits in its register while rsp_tready is low; new requests wait until it leaves.
module solitaire_keystream_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // action[1:0], position[7:2], card[13:8], letter[18:14]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // keystream[4:0], letter_out[9:5], status[10]
);
   import sks_pkg::*;

   cmd_type    cmd;
   stat_type   stat;
   logic [4:0] keystream, letter_out;
   logic       status;

   sks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tdata[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sks_dpath u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_tdata[1:0]),
      .req_position   (req_tdata[7:2]),
      .req_card       (req_tdata[13:8]),
      .req_letter     (req_tdata[18:14]),
      .rsp_keystream  (keystream),
      .rsp_letter_out (letter_out),
      .rsp_status     (status)
   );

   assign rsp_tdata = {5'd0, status, letter_out, keystream};

endmodule
